[src/c2d_pkg.sv]
// Package for the streaming 3x3 convolution core: shared types, register
// indexes and the saturating rescale of a nine-tap sum.
// No dependencies; imported by conv2d_3x3_zero_pad_core and c2d_mac.
package c2d_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int NTAPS       = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PAD_TAPS    = KERNEL_SIZE * (KERNEL_SIZE - 1);
  localparam int PIX_W       = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = PIX_W + COEF_W;
  localparam int ROW_SUM_W   = PROD_W + 2;
  localparam int SUM_W       = PROD_W + 4;
  localparam int FRAC_W      = 12;
  localparam int POS_W       = 10;
  localparam int SIZE_W      = 11;
  localparam int KROW_W      = KERNEL_SIZE * COEF_W;
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_AW     = 4;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [2:0] REG_IMG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KROW_TOP   = 3'd2;
  localparam logic [2:0] REG_KROW_MID   = 3'd3;
  localparam logic [2:0] REG_KROW_BOT   = 3'd4;

  typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] win_t;
  typedef logic [NTAPS-1:0][COEF_W-1:0] coef_t;

  // Which results an item in flight will produce, and where they sit.
  typedef struct packed {
    logic             e0;
    logic             e1;
    logic             fend;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } side_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             clipped;
    logic             fend;
  } result_t;

  // Arithmetic shift right by the coefficient fraction, then clamp to 16 bits.
  // Returns {clipped, value}.
  function automatic logic [PIX_W:0] sat_sum(input logic [SUM_W-1:0] s);
    logic [SUM_W-FRAC_W-1:0] q;
    logic                    clip;
    logic [PIX_W-1:0]        v;
    begin
      q    = s[SUM_W-1:FRAC_W];
      clip = !((&q[SUM_W-FRAC_W-1:PIX_W-1]) || (~|q[SUM_W-FRAC_W-1:PIX_W-1]));
      if (clip) begin
        v = q[SUM_W-FRAC_W-1] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
      end else begin
        v = q[PIX_W-1:0];
      end
      return {clip, v};
    end
  endfunction

endpackage

[src/conv2d_3x3_zero_pad_core.sv]
// Top level of the streaming 3x3 convolution core with zero padding.
// Depends on c2d_pkg and c2d_mac.
//
// Pixels enter in raster order, one beat per clock while in_stall is low,
// and the core returns an image of the same size convolved with a flipped
// 3x3 kernel (true convolution), with pixels outside the image taken as
// zero. Pixels are signed Q8.8, coefficients signed Q4.12; each sum is
// shifted right by 12 (rounding toward minus infinity) and saturated to 16
// bits, with out_clipped marking a saturated result. Output (y,x) appears
// once pixel (y+1,x+1) has arrived; after the last pixel of an image send
// one flush beat per column to drain the bottom row, out_frame_end marking
// the final result. The core takes one input beat every clock while in_stall
// is low: the previous two rows live in a single MAX_WIDTH x 32 line RAM that
// is read at accept and written back in the cycle after, with forwarding
// when both touch the same column. The last beat of a row yields two results
// while the first yields none; a 16-entry result queue absorbs this, and
// in_stall rises only when more than 14 results are queued or in flight,
// that is when the consumer holds out_stall. The line RAM has no reset and
// needs no clearing pass.
module conv2d_3x3_zero_pad_core import c2d_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  // Pixel input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [PIX_W-1:0]  in_pixel,
  // Result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_value,
  output logic [POS_W-1:0]  out_col,
  output logic [POS_W-1:0]  out_row,
  output logic              out_clipped,
  output logic              out_frame_end
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCMP_W = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
  localparam int HCMP_W = ((RW > SIZE_W) ? RW : SIZE_W) + 1;
  localparam int LS_W   = 2 * PIX_W;
  localparam int PEND_W = FIFO_AW + 1;
  localparam logic [PEND_W-1:0] PEND_LIMIT = PEND_W'(FIFO_DEPTH - 2);

  // ---------------------------------------------------------------- config
  logic [SIZE_W-1:0]              wid_r;
  logic [SIZE_W-1:0]              hgt_r;
  logic [KERNEL_SIZE-1:0][KROW_W-1:0] krow_r;
  logic                           cfg_wr;
  logic [2:0]                     cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r     <= SIZE_W'(1024);
      hgt_r     <= SIZE_W'(1024);
      krow_r[0] <= '0;
      krow_r[1] <= KROW_W'(48'h0000_1000_0000);
      krow_r[2] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMG_WIDTH:  wid_r     <= cfg_pwdata[SIZE_W-1:0];
        REG_IMG_HEIGHT: hgt_r     <= cfg_pwdata[SIZE_W-1:0];
        REG_KROW_TOP:   krow_r[0] <= cfg_pwdata[KROW_W-1:0];
        REG_KROW_MID:   krow_r[1] <= cfg_pwdata[KROW_W-1:0];
        REG_KROW_BOT:   krow_r[2] <= cfg_pwdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IMG_WIDTH:  cfg_prdata = CFG_DW'(wid_r);
      REG_IMG_HEIGHT: cfg_prdata = CFG_DW'(hgt_r);
      REG_KROW_TOP:   cfg_prdata = CFG_DW'(krow_r[0]);
      REG_KROW_MID:   cfg_prdata = CFG_DW'(krow_r[1]);
      REG_KROW_BOT:   cfg_prdata = CFG_DW'(krow_r[2]);
      default:        cfg_prdata = '0;
    endcase
  end

  coef_t kc;
  always_comb begin
    for (int k = 0; k < NTAPS; k++) begin
      kc[k] = krow_r[k / KERNEL_SIZE][COEF_W*(k % KERNEL_SIZE) +: COEF_W];
    end
  end

  // A zero size behaves as one; anything beyond the store behaves as its limit.
  logic [WCMP_W-1:0] eff_w;
  logic [HCMP_W-1:0] eff_h;
  always_comb begin
    if (wid_r == '0) begin
      eff_w = WCMP_W'(1);
    end else if (WCMP_W'(wid_r) > WCMP_W'(MAX_WIDTH)) begin
      eff_w = WCMP_W'(MAX_WIDTH);
    end else begin
      eff_w = WCMP_W'(wid_r);
    end
    if (hgt_r == '0) begin
      eff_h = HCMP_W'(1);
    end else if (HCMP_W'(hgt_r) > HCMP_W'(MAX_HEIGHT)) begin
      eff_h = HCMP_W'(MAX_HEIGHT);
    end else begin
      eff_h = HCMP_W'(hgt_r);
    end
  end

  // ---------------------------------------------------------- accept stage
  logic [CW-1:0]     col_r, col_nxt;
  logic [CW-1:0]     drn_r, drn_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              drain_r, drain_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  logic              acc, is_pix, live, last, row_last, r_ge1, r_ge2;
  logic [CW-1:0]     cur_c;
  side_t             sb;
  logic [1:0]        n_res;
  logic              pop;

  assign in_stall = pend_r > PEND_LIMIT;
  assign acc      = in_valid && !in_stall;
  assign is_pix   = in_cmd == CMD_PIXEL;
  assign live     = is_pix ? !drain_r : drain_r;
  assign cur_c    = is_pix ? col_r : drn_r;
  assign last     = (WCMP_W'(cur_c) + WCMP_W'(1)) >= eff_w;
  assign row_last = (HCMP_W'(row_r) + HCMP_W'(1)) >= eff_h;
  assign r_ge1    = row_r != '0;
  assign r_ge2    = row_r > RW'(1);

  always_comb begin
    sb.col = POS_W'(cur_c);
    if (is_pix) begin
      sb.e0   = r_ge1 && (cur_c != '0);
      sb.e1   = r_ge1 && last;
      sb.fend = 1'b0;
      sb.row  = POS_W'(row_r) - POS_W'(1);
    end else begin
      sb.e0   = cur_c != '0;
      sb.e1   = last;
      sb.fend = 1'b1;
      sb.row  = POS_W'(row_r);
    end
    n_res = {1'b0, sb.e0} + {1'b0, sb.e1};
  end

  always_comb begin
    col_nxt   = col_r;
    drn_nxt   = drn_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    if (acc && live) begin
      if (is_pix) begin
        if (last) begin
          col_nxt = '0;
          if (row_last) begin
            drain_nxt = 1'b1;
            drn_nxt   = '0;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = cur_c + 1'b1;
        end
      end else begin
        if (last) begin
          drain_nxt = 1'b0;
          drn_nxt   = '0;
          col_nxt   = '0;
          row_nxt   = '0;
        end else begin
          drn_nxt = cur_c + 1'b1;
        end
      end
    end
  end

  // Results are counted from accept until they leave the queue, so the
  // queue can never overflow.
  always_comb begin
    pend_nxt = pend_r - PEND_W'(pop);
    if (acc && live) begin
      pend_nxt = pend_nxt + PEND_W'(n_res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      drn_r   <= '0;
      row_r   <= '0;
      drain_r <= 1'b0;
      pend_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      drn_r   <= drn_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // ------------------------------------------------------- line store RAM
  // Upper half holds row y-2, lower half row y-1, addressed by column.
  logic [LS_W-1:0]  ls_mem [MAX_WIDTH];
  logic [LS_W-1:0]  rd_r;
  logic             fwd_r;
  logic [LS_W-1:0]  fwd_d_r;

  logic             a_v_r;
  logic             a_pix_item_r;
  logic [PIX_W-1:0] a_pix_r;
  logic [CW-1:0]    a_c_r;
  logic             a_first_r;
  logic             a_top_ok_r;
  logic             a_mid_ok_r;
  side_t            a_sb_r;

  logic [LS_W-1:0]  rdat;
  logic [LS_W-1:0]  wdata;
  logic             we;
  logic [PIX_W-1:0] old_px, new_px;
  logic [KERNEL_SIZE-1:0][PIX_W-1:0] colv;

  assign rdat   = fwd_r ? fwd_d_r : rd_r;
  assign old_px = rdat[LS_W-1:PIX_W];
  assign new_px = rdat[PIX_W-1:0];
  assign we     = a_v_r && a_pix_item_r;
  assign wdata  = {new_px, a_pix_r};

  always_ff @(posedge clk) begin
    if (we) begin
      ls_mem[a_c_r] <= wdata;
    end
    if (acc) begin
      rd_r    <= ls_mem[cur_c];
      // The write-back of the previous beat lands at this same edge.
      fwd_r   <= we && (a_c_r == cur_c);
      fwd_d_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= acc && live;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_pix_item_r <= is_pix;
      a_pix_r      <= in_pixel;
      a_c_r        <= cur_c;
      a_first_r    <= cur_c == '0;
      a_top_ok_r   <= is_pix ? r_ge2 : r_ge1;
      a_mid_ok_r   <= is_pix ? r_ge1 : 1'b1;
      a_sb_r       <= sb;
    end
  end

  // --------------------------------------------------------------- window
  win_t  win_r;
  logic  b_v_r;
  side_t b_sb_r;

  assign colv[0] = a_top_ok_r ? old_px : '0;
  assign colv[1] = a_mid_ok_r ? new_px : '0;
  assign colv[2] = a_pix_item_r ? a_pix_r : '0;

  // A new row starts from an all-zero window, which supplies the left pad.
  always_ff @(posedge clk) begin
    if (a_v_r) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
          win_r[j][i] <= a_first_r ? '0 : win_r[j][i+1];
        end
        win_r[j][KERNEL_SIZE-1] <= colv[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_sb_r <= a_sb_r;
  end

  // ------------------------------------------------------------------ MAC
  logic                    s_v;
  side_t                   s_sb;
  logic signed [SUM_W-1:0] sum0, sum1;

  c2d_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (b_v_r),
    .in_sb  (b_sb_r),
    .win    (win_r),
    .coef   (kc),
    .out_v  (s_v),
    .out_sb (s_sb),
    .sum0   (sum0),
    .sum1   (sum1)
  );

  // --------------------------------------------------------- result queue
  result_t            fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, rptr_r;
  logic [PEND_W-1:0]  cnt_r;
  logic               push0, push1;
  logic [PIX_W:0]     sat0, sat1;
  result_t            res0, res1, head;

  assign push0 = s_v && s_sb.e0;
  assign push1 = s_v && s_sb.e1;
  assign sat0  = sat_sum(sum0);
  assign sat1  = sat_sum(sum1);

  always_comb begin
    res0.value   = sat0[PIX_W-1:0];
    res0.clipped = sat0[PIX_W];
    res0.col     = s_sb.col - POS_W'(1);
    res0.row     = s_sb.row;
    res0.fend    = 1'b0;
    res1.value   = sat1[PIX_W-1:0];
    res1.clipped = sat1[PIX_W];
    res1.col     = s_sb.col;
    res1.row     = s_sb.row;
    res1.fend    = s_sb.fend;
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_r[wptr_r] <= res0;
    end
    if (push1) begin
      fifo_r[push0 ? wptr_r + 1'b1 : wptr_r] <= res1;
    end
  end

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + FIFO_AW'(push0) + FIFO_AW'(push1);
      rptr_r <= rptr_r + FIFO_AW'(pop);
      cnt_r  <= cnt_r + PEND_W'(push0) + PEND_W'(push1) - PEND_W'(pop);
    end
  end

  assign head          = fifo_r[rptr_r];
  assign out_value     = head.value;
  assign out_col       = head.col;
  assign out_row       = head.row;
  assign out_clipped   = head.clipped;
  assign out_frame_end = head.fend;

endmodule

[src/c2d_mac.sv]
// Multiply-accumulate pipeline of the 3x3 convolution core: two kernel
// passes over the window (plain and zero-padded right edge), three stages.
// Depends on c2d_pkg.
module c2d_mac import c2d_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_v,
  input  side_t                   in_sb,
  input  win_t                    win,
  input  coef_t                   coef,
  output logic                    out_v,
  output side_t                   out_sb,
  output logic signed [SUM_W-1:0] sum0,
  output logic signed [SUM_W-1:0] sum1
);

  logic                        c_v_r;
  side_t                       c_sb_r;
  logic signed [PROD_W-1:0]    p0_r [NTAPS];
  logic signed [PROD_W-1:0]    p1_r [PAD_TAPS];

  logic                        d_v_r;
  side_t                       d_sb_r;
  logic signed [ROW_SUM_W-1:0] r0_r [KERNEL_SIZE];
  logic signed [ROW_SUM_W-1:0] r1_r [KERNEL_SIZE];

  logic                        e_v_r;
  side_t                       e_sb_r;
  logic signed [SUM_W-1:0]     sum0_r;
  logic signed [SUM_W-1:0]     sum1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      c_v_r <= in_v;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
    end
  end

  // The kernel is flipped: window tap (j,i) meets coefficient 8-3j-i.
  // The padded pass takes the window one column to the left with a zero
  // column on the right, so its right-hand column contributes nothing.
  always_ff @(posedge clk) begin
    c_sb_r <= in_sb;
    for (int j = 0; j < KERNEL_SIZE; j++) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        p0_r[j*KERNEL_SIZE+i] <= $signed(win[j][i])
                                 * $signed(coef[NTAPS-1-KERNEL_SIZE*j-i]);
      end
      for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
        p1_r[j*(KERNEL_SIZE-1)+i] <= $signed(win[j][i+1])
                                     * $signed(coef[NTAPS-1-KERNEL_SIZE*j-i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    d_sb_r <= c_sb_r;
    for (int j = 0; j < KERNEL_SIZE; j++) begin
      r0_r[j] <= p0_r[j*KERNEL_SIZE] + p0_r[j*KERNEL_SIZE+1] + p0_r[j*KERNEL_SIZE+2];
      r1_r[j] <= p1_r[j*(KERNEL_SIZE-1)] + p1_r[j*(KERNEL_SIZE-1)+1];
    end
  end

  always_ff @(posedge clk) begin
    e_sb_r <= d_sb_r;
    sum0_r <= r0_r[0] + r0_r[1] + r0_r[2];
    sum1_r <= r1_r[0] + r1_r[1] + r1_r[2];
  end

  assign out_v  = e_v_r;
  assign out_sb = e_sb_r;
  assign sum0   = sum0_r;
  assign sum1   = sum1_r;

endmodule

[src/c2d_checker.sv]
// Port-level checks for the 3x3 convolution core: result beat ordering,
// saturation coding, output hold under stall and the restart after frame end.
// Bound to conv2d_3x3_zero_pad_core; no package dependency.
module c2d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_value,
  input logic [9:0]  out_col,
  input logic [9:0]  out_row,
  input logic        out_clipped,
  input logic        out_frame_end
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_value) && $stable(out_col)
                                  && $stable(out_row) && $stable(out_frame_end)))
    else $error("result beat changed while stalled");

  // Back-to-back result beats walk along a row or start a new one.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(out_valid && !out_stall) && out_valid && !out_stall)
      |-> ((out_col == 10'd0)
           || ((out_col == $past(out_col) + 10'd1) && (out_row == $past(out_row)))))
    else $error("result beats out of raster order");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> ((out_value == 16'h7fff) || (out_value == 16'h8000)))
    else $error("clipped result is not a saturation value");

  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(out_valid && !out_stall && out_frame_end) && out_valid)
      |-> ((out_col == 10'd0) && (out_row == 10'd0)))
    else $error("image after frame end does not start at the origin");

endmodule

bind conv2d_3x3_zero_pad_core c2d_checker u_c2d_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value     (out_value),
  .out_col       (out_col),
  .out_row       (out_row),
  .out_clipped   (out_clipped),
  .out_frame_end (out_frame_end)
);
